// ----- src/trtcm_pkg.sv -----
// shared types and constants for the two-rate three-color policer
// no dependencies; used by trtcm_refill and the top level
package trtcm_pkg;

    localparam int unsigned NS_PER_US  = 1000;
    // 1000 = 8 * 125: shift off the factor of eight, then divide by 125
    localparam int unsigned US_SHIFT   = 3;
    localparam int unsigned US_ODD     = NS_PER_US >> US_SHIFT;
    localparam int unsigned DIGIT_W    = 16;
    localparam int unsigned DIGITS     = 64 / DIGIT_W;
    localparam int unsigned REM_W      = 7;
    localparam int unsigned DIV_SHIFT  = 30;
    // ceil(2^30 / 125), exact for 23-bit dividends
    localparam int unsigned DIV_MAGIC  = 8589935;
    // elapsed-time register, digit stages, product, saturation
    localparam int unsigned REFILL_LAT = DIGITS + 3;

    typedef enum logic [1:0] {
        COLOR_NONE   = 2'd0,
        COLOR_GREEN  = 2'd1,
        COLOR_YELLOW = 2'd2,
        COLOR_RED    = 2'd3
    } color_t;

    typedef enum logic [1:0] {
        VERDICT_PASS      = 2'd0,
        VERDICT_DROP      = 2'd1,
        VERDICT_BAD_COLOR = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        REG_COMMITTED_RATE  = 3'd0,
        REG_EXCESS_RATE     = 3'd1,
        REG_COMMITTED_BURST = 3'd2,
        REG_EXCESS_BURST    = 3'd3,
        REG_COLOR_AWARE     = 3'd4,
        REG_DROP_PRIORITY   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [63:0] now_ns;
        logic [15:0] packet_length;
        color_t      in_color;
    } pkt_t;

    typedef struct packed {
        color_t      out_color;
        verdict_t    verdict;
        logic [31:0] passed_total;
        logic [31:0] dropped_total;
    } res_t;

endpackage

// ----- src/trtcm_refill.sv -----
// token refill for one bucket: stamp tracking, elapsed microseconds, rate product
// depends on trtcm_pkg; output is aligned REFILL_LAT stages after the input register
module trtcm_refill (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] now,
    input  logic [31:0] rate,
    output logic [31:0] add
);

    localparam int unsigned V_W = trtcm_pkg::REM_W + trtcm_pkg::DIGIT_W;
    localparam int unsigned ND  = trtcm_pkg::DIGITS;

    function automatic logic [trtcm_pkg::DIGIT_W-1:0] div_odd(input logic [V_W-1:0] v);
        logic [V_W+23:0] prod;
        prod = (V_W+24)'(v) * (V_W+24)'(trtcm_pkg::DIV_MAGIC);
        return prod[trtcm_pkg::DIV_SHIFT +: trtcm_pkg::DIGIT_W];
    endfunction

    logic [63:0] stamp_reg;
    logic [63:0] stamp_next;
    logic [63:0] diff;
    logic        hit;

    logic [63:0]              x_reg [0:ND-1];
    logic [63:0]              q_reg [1:ND];
    logic [trtcm_pkg::REM_W-1:0] r_reg [1:ND-1];

    logic [63:0] prod_reg;
    logic        big_reg;
    logic [31:0] add_reg;

    // a refill only happens once a whole microsecond has passed
    assign diff = now - stamp_reg;
    assign hit  = (rate != '0) && (diff >= 64'(trtcm_pkg::NS_PER_US));

    always_comb
    begin
        stamp_next = stamp_reg;
        if (en && in_valid && hit)
        begin
            stamp_next = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
        end
        else
        begin
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= diff >> trtcm_pkg::US_SHIFT;
        end
    end

    // long division by 125, one 16-bit digit per stage
    for (genvar i = 0; i < ND; i++)
    begin : g_digit
        logic [V_W-1:0]                 v;
        logic [trtcm_pkg::DIGIT_W-1:0]  dq;
        logic [trtcm_pkg::REM_W-1:0]    r_in;
        logic [trtcm_pkg::REM_W-1:0]    r_out;
        logic [63:0]                    q_in;

        if (i == 0)
        begin : g_first
            assign r_in = '0;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = r_reg[i];
            assign q_in = q_reg[i];
        end

        assign v     = {r_in, x_reg[i][63 -: trtcm_pkg::DIGIT_W]};
        assign dq    = div_odd(v);
        assign r_out = trtcm_pkg::REM_W'(v - V_W'(dq) * V_W'(trtcm_pkg::US_ODD));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i+1] <= {q_in[63-trtcm_pkg::DIGIT_W:0], dq};
            end
        end

        if (i < ND - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1] <= x_reg[i] << trtcm_pkg::DIGIT_W;
                    r_reg[i+1] <= r_out;
                end
            end
        end
    end

    // rate product; anything at or past 2^32 saturates since no bucket holds more
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {32'b0, q_reg[ND][31:0]} * {32'b0, rate};
            big_reg  <= (|q_reg[ND][63:32]) && (rate != '0);
            add_reg  <= (big_reg || (|prod_reg[63:32])) ? '1 : prod_reg[31:0];
        end
    end

    assign add = add_reg;

endmodule

// ----- src/two_rate_three_color_policer_unit.sv -----
// top level of the two-rate three-color policer: input pipe, marking, output skid
// depends on trtcm_pkg and trtcm_refill
//
//  channel | direction | handshake          | payload
//  pkt     | in        | pkt_valid/pkt_stall | trtcm_pkg::pkt_t
//  res     | out       | res_valid/res_stall | trtcm_pkg::res_t
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// one packet per cycle while pkt_stall is low; an accepted beat passes the input
// register and 7 refill stages set by the 16-bit division digits and the rate
// product, and marking feeds the output register directly
// reset clears buckets, stamps, counters and config, but sets drop priority to 3; no clearing pass
// a result that meets a stalled output goes to a skid register; pkt_stall rises only
// while the skid holds a beat, and then the whole pipe freezes
module two_rate_three_color_policer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    output logic              pkt_stall,
    input  trtcm_pkg::pkt_t   pkt,
    output logic              res_valid,
    input  logic              res_stall,
    output trtcm_pkg::res_t   res,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int unsigned LAST = trtcm_pkg::REFILL_LAT;

    function automatic logic [31:0] fill_bucket(input logic [31:0] tokens,
                                                input logic [31:0] add,
                                                input logic [31:0] burst);
        logic [32:0] sum;
        sum = {1'b0, tokens} + {1'b0, add};
        if (burst <= tokens)
            return tokens;
        else if (sum > {1'b0, burst})
            return burst;
        else
            return sum[31:0];
    endfunction

    // configuration
    logic [31:0] c_rate_reg;
    logic [31:0] e_rate_reg;
    logic [31:0] c_burst_reg;
    logic [31:0] e_burst_reg;
    logic        aware_reg;
    logic [1:0]  drop_prio_reg;

    // pipe
    logic                    advance;
    logic [LAST:0]           valid_reg;
    logic [63:0]             now_reg;
    logic [15:0]             len_reg   [0:LAST];
    trtcm_pkg::color_t       color_reg [0:LAST];
    logic [31:0]             c_add;
    logic [31:0]             e_add;

    // bucket state
    logic [31:0] ct_reg, ct_next;
    logic [31:0] et_reg, et_next;
    logic [31:0] pass_reg, pass_next;
    logic [31:0] drop_reg, drop_next;

    // marking
    logic                  fire;
    logic [31:0]           c_fill;
    logic [31:0]           e_fill;
    logic [31:0]           len32;
    logic [31:0]           c_mark;
    logic [31:0]           e_mark;
    trtcm_pkg::color_t     ocol;
    trtcm_pkg::verdict_t   verd;
    trtcm_pkg::res_t       fin;

    // output register and skid
    logic              out_valid_reg;
    trtcm_pkg::res_t   out_reg;
    logic              skid_valid_reg;
    trtcm_pkg::res_t   skid_reg;
    logic              out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_rate_reg    <= '0;
            e_rate_reg    <= '0;
            c_burst_reg   <= '0;
            e_burst_reg   <= '0;
            aware_reg     <= 1'b0;
            drop_prio_reg <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trtcm_pkg::REG_COMMITTED_RATE:  c_rate_reg    <= cfg_data;
                trtcm_pkg::REG_EXCESS_RATE:     e_rate_reg    <= cfg_data;
                trtcm_pkg::REG_COMMITTED_BURST: c_burst_reg   <= cfg_data;
                trtcm_pkg::REG_EXCESS_BURST:    e_burst_reg   <= cfg_data;
                trtcm_pkg::REG_COLOR_AWARE:     aware_reg     <= cfg_data[0];
                trtcm_pkg::REG_DROP_PRIORITY:   drop_prio_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign advance   = !skid_valid_reg;
    assign pkt_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAST-1:0], pkt_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            now_reg      <= pkt.now_ns;
            len_reg[0]   <= pkt.packet_length;
            color_reg[0] <= pkt.in_color;
            for (int i = 1; i <= LAST; i++)
            begin
                len_reg[i]   <= len_reg[i-1];
                color_reg[i] <= color_reg[i-1];
            end
        end
    end

    trtcm_refill u_committed (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (valid_reg[0]),
        .now      (now_reg),
        .rate     (c_rate_reg),
        .add      (c_add)
    );

    trtcm_refill u_excess (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (valid_reg[0]),
        .now      (now_reg),
        .rate     (e_rate_reg),
        .add      (e_add)
    );

    assign fire   = advance && valid_reg[LAST];
    assign c_fill = fill_bucket(ct_reg, c_add, c_burst_reg);
    assign e_fill = fill_bucket(et_reg, e_add, e_burst_reg);
    assign len32  = {16'b0, len_reg[LAST]};

    always_comb
    begin
        c_mark = c_fill;
        e_mark = e_fill;
        verd   = trtcm_pkg::VERDICT_PASS;
        if (aware_reg && color_reg[LAST] == trtcm_pkg::COLOR_NONE)
        begin
            ocol = trtcm_pkg::COLOR_NONE;
            verd = trtcm_pkg::VERDICT_BAD_COLOR;
        end
        else if (aware_reg && color_reg[LAST] == trtcm_pkg::COLOR_RED)
        begin
            ocol = trtcm_pkg::COLOR_RED;
        end
        else if (e_fill < len32)
        begin
            ocol = trtcm_pkg::COLOR_RED;
        end
        else if (c_fill < len32)
        begin
            ocol   = trtcm_pkg::COLOR_YELLOW;
            e_mark = e_fill - len32;
        end
        else
        begin
            c_mark = c_fill - len32;
            e_mark = e_fill - len32;
            ocol   = aware_reg ? color_reg[LAST] : trtcm_pkg::COLOR_GREEN;
        end

        if (ocol > drop_prio_reg)
        begin
            verd      = trtcm_pkg::VERDICT_DROP;
            drop_next = drop_reg + 32'd1;
            pass_next = pass_reg;
        end
        else
        begin
            drop_next = drop_reg;
            pass_next = pass_reg + 32'd1;
        end

        ct_next = c_mark;
        et_next = e_mark;

        fin.out_color     = ocol;
        fin.verdict       = verd;
        fin.passed_total  = pass_next;
        fin.dropped_total = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg   <= '0;
            et_reg   <= '0;
            pass_reg <= '0;
            drop_reg <= '0;
        end
        else if (fire)
        begin
            ct_reg   <= ct_next;
            et_reg   <= et_next;
            pass_reg <= pass_next;
            drop_reg <= drop_next;
        end
    end

    assign out_free = !out_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || fire;
            skid_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin;
        end
        else if (fire)
        begin
            skid_reg <= fin;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(res_valid && res_stall))
        else $error("skid filled without a stalled result");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipe moved while the skid was full");

    a_one_count_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (32'(pass_reg + drop_reg) ==
                  32'($past(pass_reg) + $past(drop_reg) + 32'd1)))
        else $error("pass and drop counts did not move by exactly one");

    a_bad_color_uncolored: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.verdict == trtcm_pkg::VERDICT_BAD_COLOR)
            |-> (res.out_color == trtcm_pkg::COLOR_NONE))
        else $error("invalid-color verdict with a color attached");

endmodule

// ----- sim/tb_two_rate_three_color_policer_unit.sv -----
// testbench for two_rate_three_color_policer_unit: directed and random packets
// checked against a bucket predictor kept in a small scoreboard class
// depends on trtcm_pkg and the policer rtl
`timescale 1ns / 100ps

module tb_two_rate_three_color_policer_unit;
    import trtcm_pkg::*;

    localparam int unsigned DRAIN_CYCLES   = REFILL_LAT + 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_PACKETS  = 232;
    localparam logic [2:0]  SPARE_INDEX_FIRST = 3'd6;
    localparam logic [2:0]  SPARE_INDEX_LAST  = 3'd7;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_RANDOM,
        FLOW_PULSED
    } flow_t;

    class marker_scoreboard;
        logic [31:0] c_rate, e_rate, c_burst, e_burst;
        logic        aware;
        logic [1:0]  drop_pri;
        logic [31:0] c_tok, e_tok;
        logic [63:0] c_stamp, e_stamp;
        logic [31:0] n_pass, n_drop;
        res_t        pending_marks[$];
        int unsigned mismatches;

        function new();
            c_rate = '0;
            e_rate = '0;
            c_burst = '0;
            e_burst = '0;
            aware = 1'b0;
            drop_pri = 2'd3;
            c_tok = '0;
            e_tok = '0;
            c_stamp = '0;
            e_stamp = '0;
            n_pass = '0;
            n_drop = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_COMMITTED_RATE:  c_rate = data;
                REG_EXCESS_RATE:     e_rate = data;
                REG_COMMITTED_BURST: c_burst = data;
                REG_EXCESS_BURST:    e_burst = data;
                REG_COLOR_AWARE:     aware = data[0];
                REG_DROP_PRIORITY:   drop_pri = data[1:0];
                default: ;
            endcase
        endfunction

        // returns {stamp, tokens} after topping up one bucket
        function logic [95:0] refill_bucket(logic [63:0] now, logic [31:0] rate,
                                            logic [31:0] burst, logic [31:0] tok,
                                            logic [63:0] stamp);
            logic [63:0] us;
            logic [95:0] prod;
            logic [63:0] add;
            logic [31:0] room;
            us = (now - stamp) / 64'(NS_PER_US);
            if (rate == 0 || us == 0)
                return {stamp, tok};
            prod = {32'd0, us} * {64'd0, rate};
            add = (prod[95:64] != 0) ? '1 : prod[63:0];
            if (burst > tok)
            begin
                room = burst - tok;
                tok = tok + ((add > {32'd0, room}) ? room : add[31:0]);
            end
            return {now, tok};
        endfunction

        function void meter_packet(pkt_t p);
            logic [95:0] r;
            logic [31:0] len;
            color_t      ocol;
            verdict_t    v;
            res_t        m;
            r = refill_bucket(p.now_ns, c_rate, c_burst, c_tok, c_stamp);
            c_stamp = r[95:32];
            c_tok = r[31:0];
            r = refill_bucket(p.now_ns, e_rate, e_burst, e_tok, e_stamp);
            e_stamp = r[95:32];
            e_tok = r[31:0];
            len = {16'd0, p.packet_length};
            v = VERDICT_PASS;
            if (aware && p.in_color == COLOR_NONE)
            begin
                ocol = COLOR_NONE;
                v = VERDICT_BAD_COLOR;
            end
            else if (aware && p.in_color == COLOR_RED)
                ocol = COLOR_RED;
            else if (e_tok < len)
                ocol = COLOR_RED;
            else if (c_tok < len)
            begin
                ocol = COLOR_YELLOW;
                e_tok = e_tok - len;
            end
            else
            begin
                c_tok = c_tok - len;
                e_tok = e_tok - len;
                ocol = aware ? p.in_color : COLOR_GREEN;
            end
            if (ocol > drop_pri)
            begin
                v = VERDICT_DROP;
                n_drop = n_drop + 1;
            end
            else
                n_pass = n_pass + 1;
            m.out_color = ocol;
            m.verdict = v;
            m.passed_total = n_pass;
            m.dropped_total = n_drop;
            pending_marks.push_back(m);
        endfunction

        function void check_mark(res_t r);
            res_t m;
            if (pending_marks.size() == 0)
            begin
                $error("result beat with no packet outstanding");
                mismatches++;
                return;
            end
            m = pending_marks.pop_front();
            if (r.out_color !== m.out_color)
            begin
                $error("out_color: expected %0d, got %0d", m.out_color, r.out_color);
                mismatches++;
            end
            if (r.verdict !== m.verdict)
            begin
                $error("verdict: expected %0d, got %0d", m.verdict, r.verdict);
                mismatches++;
            end
            if (r.passed_total !== m.passed_total)
            begin
                $error("passed_total: expected %0d, got %0d", m.passed_total, r.passed_total);
                mismatches++;
            end
            if (r.dropped_total !== m.dropped_total)
            begin
                $error("dropped_total: expected %0d, got %0d", m.dropped_total,
                       r.dropped_total);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_marks.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pkt_valid = 1'b0;
    logic        pkt_stall;
    pkt_t        pkt = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    marker_scoreboard scoreboard;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    flow_t       flow_mode = FLOW_FREE;
    int unsigned flow_run = 0;

    two_rate_three_color_policer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_packet(input logic [63:0] t, input logic [15:0] len,
                                input color_t col);
        pkt_t        p;
        int unsigned gap;
        p.now_ns = t;
        p.packet_length = len;
        p.in_color = col;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pkt_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        pkt <= p;
        pkt_valid <= 1'b1;
        do
            @(posedge clk);
        while (pkt_stall);
        scoreboard.meter_packet(p);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        scoreboard.write_reg(idx, data);
        @(negedge clk);
    endtask

    // waits for the pipe to empty, then rewrites every register
    task automatic program_policer(input logic [31:0] cr, input logic [31:0] er,
                                   input logic [31:0] cb, input logic [31:0] eb,
                                   input logic aware, input logic [1:0] pri);
        pkt_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        put_reg(REG_COMMITTED_RATE, cr);
        put_reg(REG_EXCESS_RATE, er);
        put_reg(REG_COMMITTED_BURST, cb);
        put_reg(REG_EXCESS_BURST, eb);
        // upper bits of the narrow registers are don't-care
        put_reg(REG_COLOR_AWARE, ($urandom & 32'hFFFF_FFFE) | 32'(aware));
        put_reg(REG_DROP_PRIORITY, ($urandom & 32'hFFFF_FFFC) | 32'(pri));
        put_reg(3'($urandom_range(SPARE_INDEX_FIRST, SPARE_INDEX_LAST)), $urandom);
        cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    // receiver back-pressure: free-running, random or pulsed stretches
    always @(negedge clk)
    begin : stall_gen
        logic hold;
        if (flow_run == 0)
        begin
            flow_mode = flow_t'($urandom_range(0, 2));
            flow_run = $urandom_range(20, 200);
        end
        else
            flow_run--;
        case (flow_mode)
            FLOW_FREE:   hold = 1'b0;
            FLOW_RANDOM: hold = ($urandom_range(0, 2) == 0);
            default:     hold = (flow_run % 16) < 9;
        endcase
        res_stall <= rst_n ? hold : 1'b0;
    end

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            scoreboard.check_mark(res);

    always @(posedge clk)
    begin
        if (!rst_n || (pkt_valid && !pkt_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [63:0] t;
        logic [15:0] len;
        logic [31:0] cr, er, cb, eb;
        color_t      col;
        scoreboard = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: zero rates and bursts, color-blind, nothing dropped
        issue_packet(64'd0, 16'd0, COLOR_GREEN);
        issue_packet(64'd500, 16'hFFFF, COLOR_NONE);

        program_policer(32'd10, 32'd20, 32'd1000, 32'd2000, 1'b1, 2'd2);
        issue_packet(64'd100_000, 16'd500, COLOR_NONE);   // uncolored in aware mode
        issue_packet(64'd100_400, 16'd500, COLOR_GREEN);  // under a microsecond, stamp kept
        issue_packet(64'd100_999, 16'd500, COLOR_YELLOW);
        issue_packet(64'd101_000, 16'd500, COLOR_GREEN);  // demoted to yellow
        issue_packet(64'd101_000, 16'd600, COLOR_GREEN);  // out of excess: red, dropped
        issue_packet(64'd101_000, 16'd0, COLOR_RED);
        issue_packet(64'd50_000, 16'd1000, COLOR_GREEN);  // time runs backwards
        issue_packet(64'hFFFF_FFFF_FFFF_FF00, 16'd1, COLOR_YELLOW);

        program_policer(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 2'd0);
        issue_packet(64'd0, 16'hFFFF, COLOR_RED);          // wraps forward by 256 ns
        issue_packet(64'h8000_0000_0000_0000, 16'hFFFF, COLOR_NONE); // product saturates
        issue_packet(64'h8000_0000_0000_03E7, 16'd1, COLOR_YELLOW);
        issue_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, COLOR_GREEN);

        // bursts dropped far below the tokens held
        program_policer(32'd1, 32'd1, 32'd100, 32'd100, 1'b1, 2'd1);
        issue_packet(64'd1_000, 16'd100, COLOR_NONE);
        issue_packet(64'd3_000, 16'd100, COLOR_GREEN);
        issue_packet(64'd5_000, 16'd100, COLOR_YELLOW);
        issue_packet(64'd7_000, 16'd100, COLOR_RED);

        t = 64'd10_000;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: program_policer(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 2'd3);
                1: program_policer('0, '0, '0, '0, 1'b1, 2'd0);
                2: program_policer($urandom, $urandom, $urandom, $urandom,
                                   1'($urandom), 2'($urandom));
                default:
                begin
                    cr = $urandom_range(20, 600);
                    er = cr + $urandom_range(0, 600);
                    cb = $urandom_range(64, 6000);
                    eb = cb + $urandom_range(0, 12000);
                    program_policer(cr, er, cb, eb, 1'($urandom), 2'($urandom));
                end
            endcase
            for (int n = 0; n < PHASE_PACKETS; n++)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:79]:  t = t + $urandom_range(0, 2500);
                    [80:91]: t = t + $urandom_range(0, 200_000);
                    [92:94]: t = {$urandom, $urandom};
                    [95:96]: t = t - $urandom_range(1, 3000);
                    default: t = t + ({$urandom, $urandom} >> $urandom_range(0, 40));
                endcase
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1600));
                col = color_t'($urandom_range(0, 3));
                issue_packet(t, len, col);
            end
        end

        pkt_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
